/* hw/rtl/ptph_pkg.sv */
// ----------------------------------------------------------------------------
// ptph_pkg
// Shared types, widths and constants of the time-proportioning heater
// controller: sequencer states, shared-unit control codes and register map.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ptph_pkg;

    // default number of heater channels
    localparam int CHANNELS_DEF = 4;

    // field and datapath widths
    localparam int CH_W     = 2;
    localparam int SP_W     = 12;
    localparam int TEMP_W   = 16;
    localparam int GAIN_W   = 16;
    localparam int LIM_W    = 31;
    localparam int WIN_W    = 16;
    localparam int DUTY_W   = 17;
    localparam int INTEG_W  = 32;
    localparam int OP_W     = 18;
    localparam int PROD_W   = 2 * OP_W;
    localparam int ACC_W    = 38;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int THR_W    = PROD_W - 16;

    // reset value of the window length register
    localparam logic [WIN_W-1:0] WINDOW_RESET = 16'd100;

    // duty limits in Q16
    localparam logic signed [ACC_W-1:0] ACC_DUTY_ONE = 38'sd65536;
    localparam logic signed [ACC_W-1:0] ACC_DUTY_MIN = 38'sd6554;
    localparam logic [DUTY_W-1:0] DUTY_ONE = 17'd65536;
    localparam logic [DUTY_W-1:0] DUTY_MIN = 17'd6554;

    // configuration register map
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KP      = 3'd0,
        REG_KI      = 3'd1,
        REG_KD      = 3'd2,
        REG_ILIMIT  = 3'd3,
        REG_WINDOW  = 3'd4
    } reg_index_t;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_I,
        ST_ADD_I,
        ST_CLAMP_I,
        ST_ADD_P,
        ST_ADD_D,
        ST_CLAMP_D,
        ST_WRAP,
        ST_HEAT,
        ST_DONE
    } seq_state_t;

    // multiplier operand pair
    typedef enum logic [1:0] {
        MUL_KI_ERR,
        MUL_KP_ERR,
        MUL_KD_DER,
        MUL_DUTY_WIN
    } mul_sel_t;

    // accumulator action as seen by the sequencer
    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_ADD,
        ACC_SET_INTEG,
        ACC_SET_ICLAMP
    } acc_op_t;

    // accumulator action inside the shared unit
    typedef enum logic [1:0] {
        MAC_HOLD,
        MAC_ADD,
        MAC_LOAD
    } mac_op_t;

    // sequencer to datapath
    typedef struct packed {
        logic     idle;
        logic     mul_en;
        mul_sel_t mul_sel;
        acc_op_t  acc_op;
        logic     wr_integ;
        logic     clamp_duty;
        logic     wr_heat;
        logic     out_load;
    } ctrl_t;

    // datapath to sequencer
    typedef struct packed {
        logic in_fire;
        logic en_ok;
        logic duty_zero;
        logic rem_done;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

/* hw/rtl/ptph_mac.sv */
// ----------------------------------------------------------------------------
// ptph_mac
// Shared signed multiplier with a registered product and a wide accumulator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ptph_mac (
    input  wire logic                                 clk,
    input  wire logic                                 mul_en,
    input  wire logic signed [ptph_pkg::OP_W-1:0]     op_a,
    input  wire logic signed [ptph_pkg::OP_W-1:0]     op_b,
    input  wire ptph_pkg::mac_op_t                    acc_op,
    input  wire logic signed [ptph_pkg::ACC_W-1:0]    acc_set,
    output logic signed [ptph_pkg::PROD_W-1:0]        prod,
    output logic signed [ptph_pkg::ACC_W-1:0]         acc
);

    logic signed [ptph_pkg::PROD_W-1:0] prod_reg;
    logic signed [ptph_pkg::ACC_W-1:0]  acc_reg;
    logic signed [ptph_pkg::ACC_W-1:0]  prod_ext;

    assign prod_ext = ptph_pkg::ACC_W'(prod_reg);

    // product register
    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            prod_reg <= op_a * op_b;
        end
    end

    // accumulator
    always_ff @(posedge clk)
    begin
        case (acc_op)
            ptph_pkg::MAC_ADD:  acc_reg <= acc_reg + prod_ext;
            ptph_pkg::MAC_LOAD: acc_reg <= acc_set;
            default:            acc_reg <= acc_reg;
        endcase
    end

    assign prod = prod_reg;
    assign acc  = acc_reg;

endmodule

`default_nettype wire

/* hw/rtl/ptph_rem.sv */
// ----------------------------------------------------------------------------
// ptph_rem
// Remainder of the advanced window count by the window length: done straight
// from start when the count is below twice the window, else one bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ptph_rem (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    input  wire logic [ptph_pkg::WIN_W:0]         num,
    input  wire logic [ptph_pkg::WIN_W-1:0]       den,
    output logic                                  done,
    output logic [ptph_pkg::WIN_W-1:0]            rem
);

    localparam int NUM_W  = ptph_pkg::WIN_W + 1;
    localparam int STEP_W = $clog2(NUM_W);

    logic                  busy_reg;
    logic                  done_reg;
    logic [STEP_W-1:0]     step_reg;
    logic [NUM_W-1:0]      num_reg;
    logic [NUM_W-1:0]      rem_reg;
    logic [NUM_W-1:0]      den_ext;
    logic [NUM_W-1:0]      den_dbl;
    logic [NUM_W-1:0]      partial;

    assign den_ext = {1'b0, den};
    assign den_dbl = {den, 1'b0};
    assign partial = {rem_reg[NUM_W-2:0], num_reg[step_reg]};

    // control: fast cases finish at once, the rest walks the bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            step_reg <= STEP_W'(NUM_W - 1);
            if (num < den_ext || num < den_dbl)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else
            begin
                busy_reg <= 1'b1;
                done_reg <= 1'b0;
            end
        end
        else if (busy_reg)
        begin
            if (step_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else
            begin
                step_reg <= step_reg - 1'b1;
            end
        end
    end

    // partial remainder
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            if (num < den_ext)
            begin
                rem_reg <= num;
            end
            else if (num < den_dbl)
            begin
                rem_reg <= num - den_ext;
            end
            else
            begin
                rem_reg <= '0;
            end
        end
        else if (busy_reg)
        begin
            if (partial >= den_ext)
            begin
                rem_reg <= partial - den_ext;
            end
            else
            begin
                rem_reg <= partial;
            end
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg[ptph_pkg::WIN_W-1:0];

endmodule

`default_nettype wire

/* hw/rtl/ptph_seq.sv */
// ----------------------------------------------------------------------------
// ptph_seq
// Sequencer that steps one control sample through the shared unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ptph_seq (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire ptph_pkg::status_t  status,
    output ptph_pkg::ctrl_t         ctrl
);

    ptph_pkg::seq_state_t state_reg;
    ptph_pkg::seq_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ptph_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ptph_pkg::ST_IDLE:
            begin
                if (status.in_fire)
                begin
                    state_next = status.en_ok ? ptph_pkg::ST_MUL_I : ptph_pkg::ST_DONE;
                end
            end
            ptph_pkg::ST_MUL_I:   state_next = ptph_pkg::ST_ADD_I;
            ptph_pkg::ST_ADD_I:   state_next = ptph_pkg::ST_CLAMP_I;
            ptph_pkg::ST_CLAMP_I: state_next = ptph_pkg::ST_ADD_P;
            ptph_pkg::ST_ADD_P:   state_next = ptph_pkg::ST_ADD_D;
            ptph_pkg::ST_ADD_D:   state_next = ptph_pkg::ST_CLAMP_D;
            ptph_pkg::ST_CLAMP_D:
            begin
                state_next = status.duty_zero ? ptph_pkg::ST_DONE : ptph_pkg::ST_WRAP;
            end
            ptph_pkg::ST_WRAP:
            begin
                if (status.rem_done)
                begin
                    state_next = ptph_pkg::ST_HEAT;
                end
            end
            ptph_pkg::ST_HEAT:    state_next = ptph_pkg::ST_DONE;
            ptph_pkg::ST_DONE:
            begin
                if (status.out_free)
                begin
                    state_next = ptph_pkg::ST_IDLE;
                end
            end
            default:              state_next = ptph_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        ctrl            = '0;
        ctrl.mul_sel    = ptph_pkg::MUL_KI_ERR;
        ctrl.acc_op     = ptph_pkg::ACC_HOLD;
        unique case (state_reg)
            ptph_pkg::ST_IDLE:
            begin
                ctrl.idle = 1'b1;
            end
            ptph_pkg::ST_MUL_I:
            begin
                ctrl.mul_en  = 1'b1;
                ctrl.mul_sel = ptph_pkg::MUL_KI_ERR;
                ctrl.acc_op  = ptph_pkg::ACC_SET_INTEG;
            end
            ptph_pkg::ST_ADD_I:
            begin
                ctrl.acc_op = ptph_pkg::ACC_ADD;
            end
            ptph_pkg::ST_CLAMP_I:
            begin
                ctrl.acc_op   = ptph_pkg::ACC_SET_ICLAMP;
                ctrl.wr_integ = 1'b1;
                ctrl.mul_en   = 1'b1;
                ctrl.mul_sel  = ptph_pkg::MUL_KP_ERR;
            end
            ptph_pkg::ST_ADD_P:
            begin
                ctrl.acc_op  = ptph_pkg::ACC_ADD;
                ctrl.mul_en  = 1'b1;
                ctrl.mul_sel = ptph_pkg::MUL_KD_DER;
            end
            ptph_pkg::ST_ADD_D:
            begin
                ctrl.acc_op = ptph_pkg::ACC_ADD;
            end
            ptph_pkg::ST_CLAMP_D:
            begin
                ctrl.clamp_duty = 1'b1;
            end
            ptph_pkg::ST_WRAP:
            begin
                ctrl.mul_en  = 1'b1;
                ctrl.mul_sel = ptph_pkg::MUL_DUTY_WIN;
            end
            ptph_pkg::ST_HEAT:
            begin
                ctrl.wr_heat = 1'b1;
            end
            ptph_pkg::ST_DONE:
            begin
                ctrl.out_load = status.out_free;
            end
            default:
            begin
                ctrl.idle = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

/* hw/rtl/pid_time_proportioning_heater_unit.sv */
// ----------------------------------------------------------------------------
// pid_time_proportioning_heater_unit
// PID heater controller with a time-proportioning relay output per channel.
// ----------------------------------------------------------------------------
// A disabled sample goes straight to its result; an enabled one with zero duty
// skips the relay window, and one with positive duty also waits for the window
// remainder, which takes 17 bit steps when the window count lies at or beyond
// twice a shortened window. Samples are taken one at a time, and enabled ones
// share the 18x18 multiplier that forms ki*e, kp*e, kd*d, duty*window.
// Reset clears all channel state and loads the registers with their defaults.
`timescale 1ns / 1ps
`default_nettype none

module pid_time_proportioning_heater_unit #(
    parameter int CHANNELS = ptph_pkg::CHANNELS_DEF
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    // sample channel
    input  wire logic                                   in_valid,
    output logic                                        in_stall,
    input  wire logic [ptph_pkg::CH_W-1:0]              channel,
    input  wire logic [ptph_pkg::SP_W-1:0]              setpoint,
    input  wire logic signed [ptph_pkg::TEMP_W-1:0]     measured_temp,
    input  wire logic                                   enable,
    // result channel
    output logic                                        out_valid,
    input  wire logic                                   out_stall,
    output logic                                        heat_on,
    output logic [ptph_pkg::DUTY_W-1:0]                 duty,
    // register writes
    input  wire logic                                   cfg_valid,
    output logic                                        cfg_ready,
    input  wire logic [ptph_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [ptph_pkg::CFG_DATA_W-1:0]        cfg_data
);

    localparam int IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int OP_W   = ptph_pkg::OP_W;
    localparam int ACC_W  = ptph_pkg::ACC_W;
    localparam int WIN_W  = ptph_pkg::WIN_W;

    // configuration registers
    logic [ptph_pkg::GAIN_W-1:0] kp_reg;
    logic [ptph_pkg::GAIN_W-1:0] ki_reg;
    logic [ptph_pkg::GAIN_W-1:0] kd_reg;
    logic [ptph_pkg::LIM_W-1:0]  ilimit_reg;
    logic [WIN_W-1:0]            window_reg;

    // per-channel state
    logic signed [ptph_pkg::TEMP_W-1:0]  prev_reg  [CHANNELS];
    logic signed [ptph_pkg::INTEG_W-1:0] integ_reg [CHANNELS];
    logic [WIN_W-1:0]                    count_reg [CHANNELS];

    // sample in flight
    logic [IDX_W-1:0]                    ch_reg;
    logic signed [ptph_pkg::TEMP_W-1:0]  meas_reg;
    logic signed [OP_W-1:0]              err_reg;
    logic signed [OP_W-1:0]              der_reg;
    logic signed [ptph_pkg::INTEG_W-1:0] integ_old_reg;
    logic [ptph_pkg::DUTY_W-1:0]         duty_reg;
    logic                                heat_reg;

    // result register
    logic                                out_valid_reg;
    logic                                out_heat_reg;
    logic [ptph_pkg::DUTY_W-1:0]         out_duty_reg;

    ptph_pkg::ctrl_t   ctrl;
    ptph_pkg::status_t status;

    logic                     in_fire;
    logic                     en_ok;
    logic [IDX_W-1:0]         in_idx;
    logic signed [OP_W-1:0]   sp_scaled;
    logic signed [OP_W-1:0]   meas_ext;
    logic signed [OP_W-1:0]   err_now;
    logic signed [OP_W-1:0]   der_now;
    logic [WIN_W-1:0]         win_eff;
    logic [WIN_W:0]           count_inc;

    logic signed [OP_W-1:0]   op_a;
    logic signed [OP_W-1:0]   op_b;
    ptph_pkg::mac_op_t        mac_op;
    logic signed [ACC_W-1:0]  acc_set;
    logic signed [ptph_pkg::PROD_W-1:0] prod;
    logic signed [ACC_W-1:0]  acc;

    logic signed [ACC_W-1:0]  lim_pos;
    logic signed [ACC_W-1:0]  lim_neg;
    logic signed [ACC_W-1:0]  iclamp;
    logic [ptph_pkg::DUTY_W-1:0] duty_clamp;
    logic                     duty_zero;
    logic                     rem_done;
    logic [WIN_W-1:0]         rem;
    logic [ptph_pkg::THR_W-1:0] thr;

    // handshakes
    assign in_stall  = !ctrl.idle;
    assign in_fire   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign en_ok     = enable && (int'(channel) < CHANNELS);
    assign in_idx    = IDX_W'(channel);

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg     <= '0;
            ki_reg     <= '0;
            kd_reg     <= '0;
            ilimit_reg <= '0;
            window_reg <= ptph_pkg::WINDOW_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                ptph_pkg::REG_KP:     kp_reg     <= cfg_data[ptph_pkg::GAIN_W-1:0];
                ptph_pkg::REG_KI:     ki_reg     <= cfg_data[ptph_pkg::GAIN_W-1:0];
                ptph_pkg::REG_KD:     kd_reg     <= cfg_data[ptph_pkg::GAIN_W-1:0];
                ptph_pkg::REG_ILIMIT: ilimit_reg <= cfg_data[ptph_pkg::LIM_W-1:0];
                ptph_pkg::REG_WINDOW: window_reg <= cfg_data[WIN_W-1:0];
                default:              kp_reg     <= kp_reg;
            endcase
        end
    end

    // error and derivative on measurement
    assign sp_scaled = $signed({2'b00, setpoint, 4'b0000});
    assign meas_ext  = OP_W'(measured_temp);
    assign err_now   = sp_scaled - meas_ext;
    assign der_now   = OP_W'(prev_reg[in_idx]) - meas_ext;

    // window length zero acts as one
    assign win_eff   = (window_reg == '0) ? WIN_W'(1) : window_reg;
    assign count_inc = {1'b0, count_reg[in_idx]} + 1'b1;

    // capture the sample transaction
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            ch_reg        <= in_idx;
            meas_reg      <= measured_temp;
            err_reg       <= err_now;
            der_reg       <= der_now;
            integ_old_reg <= integ_reg[in_idx];
        end
    end

    // multiplier operand select
    always_comb
    begin
        case (ctrl.mul_sel)
            ptph_pkg::MUL_KI_ERR:
            begin
                op_a = $signed({2'b00, ki_reg});
                op_b = err_reg;
            end
            ptph_pkg::MUL_KP_ERR:
            begin
                op_a = $signed({2'b00, kp_reg});
                op_b = err_reg;
            end
            ptph_pkg::MUL_KD_DER:
            begin
                op_a = $signed({2'b00, kd_reg});
                op_b = der_reg;
            end
            default:
            begin
                op_a = $signed({1'b0, duty_reg});
                op_b = $signed({2'b00, win_eff});
            end
        endcase
    end

    // integral clamp to the symmetric limit
    assign lim_pos = $signed({{(ACC_W - ptph_pkg::LIM_W){1'b0}}, ilimit_reg});
    assign lim_neg = -lim_pos;

    always_comb
    begin
        if (acc > lim_pos)
        begin
            iclamp = lim_pos;
        end
        else if (acc < lim_neg)
        begin
            iclamp = lim_neg;
        end
        else
        begin
            iclamp = acc;
        end
    end

    // accumulator action
    always_comb
    begin
        acc_set = iclamp;
        case (ctrl.acc_op)
            ptph_pkg::ACC_ADD:
            begin
                mac_op = ptph_pkg::MAC_ADD;
            end
            ptph_pkg::ACC_SET_INTEG:
            begin
                mac_op  = ptph_pkg::MAC_LOAD;
                acc_set = ACC_W'(integ_old_reg);
            end
            ptph_pkg::ACC_SET_ICLAMP:
            begin
                mac_op = ptph_pkg::MAC_LOAD;
            end
            default:
            begin
                mac_op = ptph_pkg::MAC_HOLD;
            end
        endcase
    end

    ptph_mac u_mac (
        .clk     (clk),
        .mul_en  (ctrl.mul_en),
        .op_a    (op_a),
        .op_b    (op_b),
        .acc_op  (mac_op),
        .acc_set (acc_set),
        .prod    (prod),
        .acc     (acc)
    );

    ptph_rem u_rem (
        .clk   (clk),
        .rst_n (rst_n),
        .start (in_fire && en_ok),
        .num   (count_inc),
        .den   (win_eff),
        .done  (rem_done),
        .rem   (rem)
    );

    // duty clamp to [0, 1.0] with a floor of 0.1 when positive
    assign duty_zero = (acc <= 0);

    always_comb
    begin
        if (duty_zero)
        begin
            duty_clamp = '0;
        end
        else if (acc > ptph_pkg::ACC_DUTY_ONE)
        begin
            duty_clamp = ptph_pkg::DUTY_ONE;
        end
        else if (acc < ptph_pkg::ACC_DUTY_MIN)
        begin
            duty_clamp = ptph_pkg::DUTY_MIN;
        end
        else
        begin
            duty_clamp = acc[ptph_pkg::DUTY_W-1:0];
        end
    end

    // on-time threshold in window ticks
    assign thr = prod[ptph_pkg::PROD_W-1:16];

    // result of the sample in flight
    always_ff @(posedge clk)
    begin
        if (in_fire && !en_ok)
        begin
            duty_reg <= '0;
            heat_reg <= 1'b0;
        end
        else if (ctrl.clamp_duty)
        begin
            duty_reg <= duty_clamp;
            heat_reg <= 1'b0;
        end
        else if (ctrl.wr_heat)
        begin
            heat_reg <= (ptph_pkg::THR_W'(rem) <= thr);
        end
    end

    // channel state updates
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                prev_reg[i]  <= '0;
                integ_reg[i] <= '0;
                count_reg[i] <= '0;
            end
        end
        else
        begin
            if (ctrl.wr_integ)
            begin
                prev_reg[ch_reg]  <= meas_reg;
                integ_reg[ch_reg] <= iclamp[ptph_pkg::INTEG_W-1:0];
            end
            if (ctrl.clamp_duty && duty_zero)
            begin
                count_reg[ch_reg] <= '0;
            end
            else if (ctrl.wr_heat)
            begin
                count_reg[ch_reg] <= rem;
            end
        end
    end

    // output register
    assign status.out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.out_load)
        begin
            out_heat_reg <= heat_reg;
            out_duty_reg <= duty_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign heat_on   = out_heat_reg;
    assign duty      = out_duty_reg;

    // sequencer
    assign status.in_fire   = in_fire;
    assign status.en_ok     = en_ok;
    assign status.duty_zero = duty_zero;
    assign status.rem_done  = rem_done;

    ptph_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

endmodule

`default_nettype wire

/* hw/rtl/ptph_checker.sv */
// ----------------------------------------------------------------------------
// ptph_checker
// Port-level checks of the heater controller, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ptph_checker (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    input  wire logic                           in_stall,
    input  wire logic                           out_valid,
    input  wire logic                           out_stall,
    input  wire logic                           heat_on,
    input  wire logic [ptph_pkg::DUTY_W-1:0]    duty
);

    // one sample at a time: no new transaction right after one is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
    else $error("sample taken while another is in flight");

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(duty) && $stable(heat_on))
    else $error("stalled result changed");

    // heater runs only with a positive duty
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && heat_on |-> duty != '0)
    else $error("heater on with zero duty");

    // duty is zero or within [0.1, 1.0]
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> duty == '0 ||
                      (duty >= ptph_pkg::DUTY_MIN && duty <= ptph_pkg::DUTY_ONE))
    else $error("duty outside its range");

endmodule

bind pid_time_proportioning_heater_unit ptph_checker u_ptph_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .heat_on   (heat_on),
    .duty      (duty)
);

`default_nettype wire

/* tb/ptph_result_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptph_result_checker
// Watches the sample, result and register channels of the heater controller.
// It keeps its own copy of the gains, the window length and the per-channel
// loop state. For each accepted sample it predicts heat_on and duty, then
// compares every accepted result with the oldest prediction.
// ----------------------------------------------------------------------------

module ptph_result_checker
    import ptph_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    input  wire logic                       in_stall,
    input  wire logic [CH_W-1:0]            channel,
    input  wire logic [SP_W-1:0]            setpoint,
    input  wire logic signed [TEMP_W-1:0]   measured_temp,
    input  wire logic                       enable,
    input  wire logic                       out_valid,
    input  wire logic                       out_stall,
    input  wire logic                       heat_on,
    input  wire logic [DUTY_W-1:0]          duty,
    input  wire logic                       cfg_valid,
    input  wire logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [CFG_DATA_W-1:0]      cfg_data,
    output int                              mismatch_count,
    output int                              pending_results
);

    localparam longint FULL_DUTY  = longint'(DUTY_ONE);
    localparam longint FLOOR_DUTY = longint'(DUTY_MIN);
    localparam int     SHOWN_MAX  = 10;

    typedef struct packed {
        logic              heat;
        logic [DUTY_W-1:0] duty;
    } heater_out_t;

    // shadow copy of the register file
    logic [GAIN_W-1:0]  gain_p;
    logic [GAIN_W-1:0]  gain_i;
    logic [GAIN_W-1:0]  gain_d;
    logic [LIM_W-1:0]   integ_limit;
    logic [WIN_W-1:0]   win_len;

    // per-channel loop state
    logic signed [TEMP_W-1:0]  meas_hist [CHANNELS];
    logic signed [INTEG_W-1:0] integ_acc [CHANNELS];
    logic [WIN_W-1:0]          win_pos   [CHANNELS];

    heater_out_t predicted_outputs [$];
    heater_out_t oldest;

    // one control step: update the channel state and return heater drive
    function automatic heater_out_t control_step(
        input logic [CH_W-1:0]          ch,
        input logic [SP_W-1:0]          sp,
        input logic signed [TEMP_W-1:0] mt,
        input logic                     en
    );
        heater_out_t r;
        longint      err;
        longint      der;
        longint      lim;
        longint      integ;
        longint      d;
        longint      thr;
        int unsigned wl;
        int unsigned cnt;
        r = '0;
        if (!en || ch >= CHANNELS)
            return r;

        err = longint'(sp) * 16 - longint'(mt);
        der = longint'(meas_hist[ch]) - longint'(mt);
        meas_hist[ch] = mt;

        // integral term with symmetric clamp
        lim = longint'(integ_limit);
        integ = longint'(integ_acc[ch]) + longint'(gain_i) * err;
        if (integ > lim)
            integ = lim;
        else if (integ < -lim)
            integ = -lim;
        integ_acc[ch] = integ[INTEG_W-1:0];

        // duty with clamp to [0, 1.0]
        d = longint'(gain_p) * err + longint'(gain_d) * der + integ;
        if (d < 0)
            d = 0;
        else if (d > FULL_DUTY)
            d = FULL_DUTY;

        // relay window
        if (d > 0)
        begin
            if (d < FLOOR_DUTY)
                d = FLOOR_DUTY;
            wl = (win_len == '0) ? 32'd1 : 32'(win_len);
            cnt = (32'(win_pos[ch]) + 32'd1) % wl;
            win_pos[ch] = cnt[WIN_W-1:0];
            thr = (d * longint'(wl)) >> 16;
            r.heat = (longint'(cnt) <= thr);
        end
        else
        begin
            win_pos[ch] = '0;
            r.heat = 1'b0;
        end
        r.duty = d[DUTY_W-1:0];
        return r;
    endfunction

    task automatic note_mismatch(input string what, input heater_out_t want);
        if (mismatch_count < SHOWN_MAX)
            $display("%0t: %s: expected heat_on=%0b duty=%0d, got heat_on=%0b duty=%0d",
                     $realtime, what, want.heat, want.duty, heat_on, duty);
        mismatch_count++;
    endtask

    // track transactions on all three channels
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p      = '0;
            gain_i      = '0;
            gain_d      = '0;
            integ_limit = '0;
            win_len     = WINDOW_RESET;
            for (int i = 0; i < CHANNELS; i++)
            begin
                meas_hist[i] = '0;
                integ_acc[i] = '0;
                win_pos[i]   = '0;
            end
            predicted_outputs.delete();
            mismatch_count   = 0;
            pending_results <= 0;
        end
        else
        begin
            // register write, only seen while the block is idle
            if (cfg_valid && cfg_ready)
            begin
                case (reg_index_t'(cfg_index))
                    REG_KP:     gain_p      = cfg_data[GAIN_W-1:0];
                    REG_KI:     gain_i      = cfg_data[GAIN_W-1:0];
                    REG_KD:     gain_d      = cfg_data[GAIN_W-1:0];
                    REG_ILIMIT: integ_limit = cfg_data[LIM_W-1:0];
                    REG_WINDOW: win_len     = cfg_data[WIN_W-1:0];
                    default:    ;
                endcase
            end

            // sample accepted: predict its result
            if (in_valid && !in_stall)
                predicted_outputs.push_back(
                    control_step(channel, setpoint, measured_temp, enable));

            // result accepted: compare with the oldest prediction
            if (out_valid && !out_stall)
            begin
                if (predicted_outputs.size() == 0)
                begin
                    note_mismatch("unexpected result", '0);
                end
                else
                begin
                    oldest = predicted_outputs.pop_front();
                    if (heat_on !== oldest.heat || duty !== oldest.duty)
                        note_mismatch("result mismatch", oldest);
                end
            end

            pending_results <= predicted_outputs.size();
        end
    end

endmodule

/* tb/pid_time_proportioning_heater_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_time_proportioning_heater_unit_tb
// Drives control samples and register writes into the heater controller with
// random gaps and output stalls. A directed part hits saturation, the duty
// floor, short and zero windows, integral clamping and disabled samples; a
// random part runs loop-like samples near the setpoint under many gain and
// window settings. The checker predicts and compares; this module only makes
// stimulus and gives the verdict.
// ----------------------------------------------------------------------------

module pid_time_proportioning_heater_unit_tb;

    import ptph_pkg::*;

    localparam int NUM_PHASES    = 12;
    localparam int PHASE_SAMPLES = 130;
    localparam int QUIET_LIMIT   = 3000;
    localparam int SETTLE_CYCLES = 30;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic [CH_W-1:0]          channel = '0;
    logic [SP_W-1:0]          setpoint = '0;
    logic signed [TEMP_W-1:0] measured_temp = '0;
    logic                     enable = 1'b0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic                     heat_on;
    logic [DUTY_W-1:0]        duty;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index = '0;
    logic [CFG_DATA_W-1:0]    cfg_data = '0;

    int mismatch_count;
    int pending_results;
    int quiet_cycles = 0;
    int stall_left = 0;
    int stall_len;
    bit calm = 1'b0;

    always #10 clk = ~clk;

    pid_time_proportioning_heater_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .channel       (channel),
        .setpoint      (setpoint),
        .measured_temp (measured_temp),
        .enable        (enable),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .heat_on       (heat_on),
        .duty          (duty),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    ptph_result_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .channel         (channel),
        .setpoint        (setpoint),
        .measured_temp   (measured_temp),
        .enable          (enable),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .heat_on         (heat_on),
        .duty            (duty),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results)
    );

    // random idle length: mostly none or short, now and then long
    function automatic int idle_len(input int pct_none);
        if (calm || $urandom_range(99) < pct_none)
            return 0;
        if ($urandom_range(9) != 0)
            return $urandom_range(1, 3);
        return $urandom_range(12, 40);
    endfunction

    // result side back-pressure
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else
        begin
            stall_len = idle_len(80);
            out_stall <= (stall_len != 0);
            if (stall_len != 0)
                stall_left <= stall_len - 1;
        end
    end

    // watchdog on cycles with no transaction on any channel
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // one sample transaction, valid held until accepted
    task automatic send_sample(
        input logic [CH_W-1:0]          ch,
        input logic [SP_W-1:0]          sp,
        input logic signed [TEMP_W-1:0] mt,
        input logic                     en
    );
        int gap;
        gap = idle_len(60);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        channel       <= ch;
        setpoint      <= sp;
        measured_temp <= mt;
        enable        <= en;
        in_valid      <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // wait until every predicted result has been accepted
    task automatic wait_results_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0) @(posedge clk);
    endtask

    // one register write transaction, valid left high for the next one
    task automatic write_reg(input reg_index_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    // load the whole register file, junk in unused upper bits
    task automatic load_regs(
        input logic [GAIN_W-1:0] kp,
        input logic [GAIN_W-1:0] ki,
        input logic [GAIN_W-1:0] kd,
        input logic [LIM_W-1:0]  lim,
        input logic [WIN_W-1:0]  win
    );
        wait_results_idle();
        write_reg(REG_KP,     {16'($urandom()), kp});
        write_reg(REG_KI,     {16'($urandom()), ki});
        write_reg(REG_KD,     {16'($urandom()), kd});
        write_reg(REG_ILIMIT, {1'($urandom()), lim});
        write_reg(REG_WINDOW, {16'($urandom()), win});
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic [GAIN_W-1:0] kp;
        logic [GAIN_W-1:0] ki;
        logic [GAIN_W-1:0] kd;
        logic [LIM_W-1:0]  lim;
        logic [WIN_W-1:0]  win;
        logic [SP_W-1:0]   target [CHANNELS_DEF];
        logic [CH_W-1:0]   ch;
        int                mt;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // register defaults: all gains zero, duty stays zero
        send_sample(2'd0, 12'd0, 16'sd0, 1'b1);
        send_sample(2'd3, 12'd4095, -16'sd32768, 1'b0);

        // full-scale gains: saturation both ways, disabled sample
        load_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 31'h7FFF_FFFF, 16'hFFFF);
        send_sample(2'd0, 12'd4095, -16'sd32768, 1'b1);
        send_sample(2'd1, 12'd0, 16'sd32767, 1'b1);
        send_sample(2'd2, 12'd4095, 16'sd32767, 1'b0);
        send_sample(2'd3, 12'd2048, -16'sd32768, 1'b1);
        send_sample(2'd0, 12'd0, -16'sd32768, 1'b1);

        // tiny duty raised to the floor, one-tick window
        load_regs(16'd1, 16'd0, 16'd0, 31'd0, 16'd1);
        send_sample(2'd1, 12'd100, 16'sd1590, 1'b1);
        send_sample(2'd1, 12'd100, 16'sd1590, 1'b1);

        // zero window length acts as length one
        load_regs(16'd1, 16'd0, 16'd0, 31'd0, 16'd0);
        send_sample(2'd2, 12'd10, 16'sd0, 1'b1);
        send_sample(2'd2, 12'd10, 16'sd0, 1'b1);

        // integral clamp high, then low with duty back to zero
        load_regs(16'd0, 16'd1000, 16'd0, 31'd50000, 16'd100);
        repeat (3) send_sample(2'd3, 12'd100, 16'sd0, 1'b1);
        send_sample(2'd3, 12'd0, 16'sd1600, 1'b1);

        // derivative on measurement, then counter past a shortened window
        load_regs(16'd0, 16'd0, 16'd200, 31'd0, 16'd10);
        send_sample(2'd0, 12'd0, 16'sd100, 1'b1);
        for (int k = 0; k < 7; k++)
            send_sample(2'd0, 12'd0, 16'(50 - 50 * k), 1'b1);
        load_regs(16'd0, 16'd0, 16'd200, 31'd0, 16'd2);
        send_sample(2'd0, 12'd0, -16'sd350, 1'b1);

        // random phases: loop-like samples near each channel's setpoint
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            kp = ($urandom_range(9) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 80));
            ki = ($urandom_range(9) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 6));
            kd = ($urandom_range(9) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 120));
            case ($urandom_range(3))
                0:       lim = '0;
                1:       lim = 31'($urandom_range(0, 200000));
                2:       lim = 31'($urandom());
                default: lim = 31'h7FFF_FFFF;
            endcase
            case ($urandom_range(5))
                0:       win = '0;
                1:       win = 16'($urandom_range(1, 4));
                2:       win = 16'd100;
                3:       win = 16'($urandom_range(5, 1000));
                4:       win = 16'hFFFF;
                default: win = 16'($urandom());
            endcase
            load_regs(kp, ki, kd, lim, win);
            calm = ($urandom_range(3) == 0);
            for (int c = 0; c < CHANNELS_DEF; c++)
                target[c] = 12'($urandom_range(0, 2040));

            for (int k = 0; k < PHASE_SAMPLES; k++)
            begin
                if ($urandom_range(99) < 85)
                begin
                    ch = 2'($urandom());
                    mt = 16 * int'(target[ch]) + $urandom_range(0, 1200) - 600;
                    if (mt > 32767)
                        mt = 32767;
                    send_sample(ch, target[ch], 16'(mt), ($urandom_range(19) != 0));
                end
                else
                begin
                    send_sample(2'($urandom()), 12'($urandom()), 16'($urandom()),
                                1'($urandom()));
                end
            end
            calm = 1'b0;
        end

        // drain and let any stray result show up
        wait_results_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_results == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
